// ----- design/mvs_pkg.sv -----
// mvs_pkg.sv: shared types, widths and codes for the motion vector scaler
`default_nettype none

package mvs_pkg;

    // fixed-point format of the scale factors
    localparam int FRAC_BITS = 16;

    localparam int VEC_W   = 16;
    localparam int SAD_W   = 31;
    localparam int ROOM_W  = 16;
    localparam int SCALE_W = 24;
    localparam int PEL_W   = 3;
    localparam int SHIFT_W = 5;
    localparam int CFG_W   = 31;
    localparam int IDX_W   = 3;

    localparam int FIFO_DEPTH = 4;

    // room bound: pel times room, negated on the low side
    localparam int BND_W  = ROOM_W + PEL_W + 1;
    // sad times horizontal factor, split for the second multiply
    localparam int SADX_W = SAD_W + SCALE_W;
    localparam int P_LO_W = 32;
    localparam int P_HI_W = SADX_W - P_LO_W;

    localparam logic [SAD_W-1:0] SAD_MAX = '1;

    typedef enum logic [1:0] {
        MODE_INC  = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_VEC  = 2'd2,
        MODE_PASS = 2'd3
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_SCALE_X  = 3'd1,
        REG_SCALE_Y  = 3'd2,
        REG_ADJUST   = 3'd3,
        REG_SHIFT    = 3'd4,
        REG_PEL      = 3'd5,
        REG_FALLBACK = 3'd6
    } reg_idx_t;

    // how the back end treats an item
    typedef enum logic [1:0] {
        KIND_SCALE,
        KIND_ROOM,
        KIND_PASS
    } kind_t;

    localparam logic [SCALE_W-1:0] SCALE_RESET    = SCALE_W'(1 << FRAC_BITS);
    localparam logic [PEL_W-1:0]   PEL_RESET      = PEL_W'(1);
    localparam logic [SAD_W-1:0]   FALLBACK_RESET = SAD_W'(65536);

    typedef struct packed {
        mode_t                     mode;
        logic [SCALE_W-1:0]        scale_x;
        logic [SCALE_W-1:0]        scale_y;
        logic                      adjust_subpel;
        logic signed [SHIFT_W-1:0] bit_shift;
        logic [PEL_W-1:0]          pel;
        logic [SAD_W-1:0]          fallback_sad;
    } cfg_t;

    typedef struct packed {
        logic signed [VEC_W-1:0]  vec_x;
        logic signed [VEC_W-1:0]  vec_y;
        logic [SAD_W-1:0]         block_sad;
        logic signed [ROOM_W-1:0] room_left;
        logic signed [ROOM_W-1:0] room_right;
        logic signed [ROOM_W-1:0] room_top;
        logic signed [ROOM_W-1:0] room_bottom;
    } in_item_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic [SAD_W-1:0]        out_sad;
        logic                    out_of_frame;
    } out_item_t;

    // classified request as it waits between front and back
    typedef struct packed {
        kind_t                   kind;
        logic                    scale_vec;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic                    neg_x;
        logic                    neg_y;
        logic [VEC_W-1:0]        mag_x;
        logic [VEC_W-1:0]        mag_y;
        logic [SAD_W-1:0]        sad;
        logic [SADX_W-1:0]       sad_px;
        logic signed [BND_W-1:0] x_lo;
        logic signed [BND_W-1:0] x_hi;
        logic signed [BND_W-1:0] y_lo;
        logic signed [BND_W-1:0] y_hi;
    } q_entry_t;

endpackage

`default_nettype wire

// ----- design/mvs_front.sv -----
// mvs_front.sv: request intake, mode classification and first products
`default_nettype none

module mvs_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mvs_pkg::cfg_t     cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mvs_pkg::in_item_t s_data,
    output logic                   push,
    output mvs_pkg::q_entry_t      push_data,
    input  wire logic              fifo_full
);
    import mvs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    q_entry_t entry_reg;
    q_entry_t entry_next;
    logic     accept;

    logic signed [BND_W-1:0] pel_s;

    assign push    = valid_reg && !fifo_full;
    assign s_ready = !valid_reg || !fifo_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pel_s = BND_W'({1'b0, cfg.pel});

        entry_next.vec_x = s_data.vec_x;
        entry_next.vec_y = s_data.vec_y;
        entry_next.neg_x = s_data.vec_x[VEC_W-1];
        entry_next.neg_y = s_data.vec_y[VEC_W-1];
        entry_next.mag_x = s_data.vec_x[VEC_W-1] ? VEC_W'(-s_data.vec_x)
                                                 : VEC_W'(s_data.vec_x);
        entry_next.mag_y = s_data.vec_y[VEC_W-1] ? VEC_W'(-s_data.vec_y)
                                                 : VEC_W'(s_data.vec_y);
        entry_next.sad    = s_data.block_sad;
        entry_next.sad_px = SADX_W'(s_data.block_sad) * SADX_W'(cfg.scale_x);

        entry_next.x_lo = -(pel_s * BND_W'(s_data.room_left));
        entry_next.x_hi = pel_s * BND_W'(s_data.room_right);
        entry_next.y_lo = -(pel_s * BND_W'(s_data.room_top));
        entry_next.y_hi = pel_s * BND_W'(s_data.room_bottom);

        unique case (cfg.mode)
            MODE_INC, MODE_DEC: begin
                entry_next.kind      = KIND_SCALE;
                entry_next.scale_vec = !cfg.adjust_subpel;
            end
            MODE_VEC: begin
                entry_next.kind      = KIND_ROOM;
                entry_next.scale_vec = 1'b1;
            end
            MODE_PASS: begin
                entry_next.kind      = KIND_PASS;
                entry_next.scale_vec = 1'b0;
            end
            default: begin
                entry_next.kind      = KIND_PASS;
                entry_next.scale_vec = 1'b0;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            entry_reg <= entry_next;
        end
    end

    assign push_data = entry_reg;

endmodule

`default_nettype wire

// ----- design/mvs_fifo.sv -----
// mvs_fifo.sv: short queue of classified requests between front and back
`default_nettype none

module mvs_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire mvs_pkg::q_entry_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output mvs_pkg::q_entry_t      pop_data,
    output logic                   empty
);
    import mvs_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    q_entry_t mem [FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/mvs_back.sv -----
// mvs_back.sv: scaling pipeline, room test, sad depth shift and result register
`default_nettype none

module mvs_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mvs_pkg::cfg_t     cfg,
    input  wire logic              fifo_empty,
    input  wire mvs_pkg::q_entry_t fifo_data,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mvs_pkg::out_item_t     m_data
);
    import mvs_pkg::*;

    localparam int VPROD_W = VEC_W + SCALE_W;
    localparam int VSUM_W  = VPROD_W + 1;
    localparam int RMAG_W  = VSUM_W - FRAC_BITS;
    localparam int CMP_W   = (RMAG_W + 1 > BND_W) ? RMAG_W + 1 : BND_W;
    localparam int PLO_W   = P_LO_W + SCALE_W;
    localparam int PHI_W   = P_HI_W + SCALE_W;
    localparam int TOT_W   = SAD_W + 2 * SCALE_W + 1;
    localparam int SAD_SH  = 2 * FRAC_BITS;
    localparam int SHL_MAX = (1 << (SHIFT_W - 1)) - 1;
    localparam int SHL_W   = SAD_W + SHL_MAX;

    localparam logic [VSUM_W-1:0] HALF_V = VSUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [TOT_W-1:0]  HALF_S = TOT_W'(1) << (SAD_SH - 1);
    localparam logic signed [CMP_W-1:0] V_HI = CMP_W'((1 << (VEC_W - 1)) - 1);
    localparam logic signed [CMP_W-1:0] V_LO = -(CMP_W'(1 << (VEC_W - 1)));

    typedef struct packed {
        kind_t                   kind;
        logic                    scale_vec;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic                    neg_x;
        logic                    neg_y;
        logic [SAD_W-1:0]        sad;
        logic signed [BND_W-1:0] x_lo;
        logic signed [BND_W-1:0] x_hi;
        logic signed [BND_W-1:0] y_lo;
        logic signed [BND_W-1:0] y_hi;
        logic [VPROD_W-1:0]      px;
        logic [VPROD_W-1:0]      py;
        logic [PLO_W-1:0]        plo;
        logic [PHI_W-1:0]        phi;
    } s1_t;

    typedef struct packed {
        kind_t                   kind;
        logic                    oof;
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic [SAD_W-1:0]        sad;
        logic [SAD_W-1:0]        sad_sc;
    } s2_t;

    logic      en;
    logic      s1_valid_reg;
    logic      s2_valid_reg;
    logic      out_valid_reg;
    s1_t       s1_reg;
    s1_t       s1_next;
    s2_t       s2_reg;
    s2_t       s2_next;
    out_item_t out_reg;
    out_item_t out_next;

    logic [VSUM_W-1:0]       sum_x;
    logic [VSUM_W-1:0]       sum_y;
    logic signed [CMP_W-1:0] val_x;
    logic signed [CMP_W-1:0] val_y;
    logic                    out_room;
    logic signed [VEC_W-1:0] sat_x;
    logic signed [VEC_W-1:0] sat_y;
    logic [TOT_W-1:0]        sad_tot;

    logic [SHIFT_W-1:0] rsh;
    logic [SHL_W-1:0]   shl;
    logic [SAD_W:0]     rnd;
    logic [SAD_W-1:0]   depth_sad;

    // whole pipeline advances together when the result register can move
    assign en  = !out_valid_reg || m_ready;
    assign pop = en && !fifo_empty;

    // stage 1: vector and sad multiplies
    always_comb begin
        s1_next.kind      = fifo_data.kind;
        s1_next.scale_vec = fifo_data.scale_vec;
        s1_next.vec_x     = fifo_data.vec_x;
        s1_next.vec_y     = fifo_data.vec_y;
        s1_next.neg_x     = fifo_data.neg_x;
        s1_next.neg_y     = fifo_data.neg_y;
        s1_next.sad       = fifo_data.sad;
        s1_next.x_lo      = fifo_data.x_lo;
        s1_next.x_hi      = fifo_data.x_hi;
        s1_next.y_lo      = fifo_data.y_lo;
        s1_next.y_hi      = fifo_data.y_hi;
        s1_next.px  = VPROD_W'(fifo_data.mag_x) * VPROD_W'(cfg.scale_x);
        s1_next.py  = VPROD_W'(fifo_data.mag_y) * VPROD_W'(cfg.scale_y);
        s1_next.plo = PLO_W'(fifo_data.sad_px[P_LO_W-1:0]) * PLO_W'(cfg.scale_y);
        s1_next.phi = PHI_W'(fifo_data.sad_px[SADX_W-1:P_LO_W]) * PHI_W'(cfg.scale_y);
    end

    // stage 2: rounding, room test, vector saturation, sad sum
    always_comb begin
        sum_x = VSUM_W'(s1_reg.px) + HALF_V;
        sum_y = VSUM_W'(s1_reg.py) + HALF_V;
        val_x = CMP_W'(sum_x[VSUM_W-1:FRAC_BITS]);
        val_y = CMP_W'(sum_y[VSUM_W-1:FRAC_BITS]);
        if (s1_reg.neg_x) begin
            val_x = -val_x;
        end
        if (s1_reg.neg_y) begin
            val_y = -val_y;
        end

        // room test uses the exact rounded vector, before saturation
        out_room = (val_x < CMP_W'(s1_reg.x_lo)) || (val_x > CMP_W'(s1_reg.x_hi)) ||
                   (val_y < CMP_W'(s1_reg.y_lo)) || (val_y > CMP_W'(s1_reg.y_hi));

        priority if (val_x > V_HI) begin
            sat_x = VEC_W'(V_HI);
        end else if (val_x < V_LO) begin
            sat_x = VEC_W'(V_LO);
        end else begin
            sat_x = VEC_W'(val_x);
        end
        priority if (val_y > V_HI) begin
            sat_y = VEC_W'(V_HI);
        end else if (val_y < V_LO) begin
            sat_y = VEC_W'(V_LO);
        end else begin
            sat_y = VEC_W'(val_y);
        end

        sad_tot = (TOT_W'(s1_reg.phi) << P_LO_W) + TOT_W'(s1_reg.plo) + HALF_S;

        s2_next.kind = s1_reg.kind;
        s2_next.sad  = s1_reg.sad;
        s2_next.oof  = (s1_reg.kind == KIND_ROOM) && out_room;
        s2_next.sad_sc = (|sad_tot[TOT_W-1:SAD_SH+SAD_W]) ? SAD_MAX
                                                           : sad_tot[SAD_SH+SAD_W-1:SAD_SH];
        priority if (!s1_reg.scale_vec) begin
            s2_next.out_x = s1_reg.vec_x;
            s2_next.out_y = s1_reg.vec_y;
        end else if (s2_next.oof) begin
            s2_next.out_x = '0;
            s2_next.out_y = '0;
        end else begin
            s2_next.out_x = sat_x;
            s2_next.out_y = sat_y;
        end
    end

    // stage 3: bit-depth shift and final sad selection
    always_comb begin
        rsh = SHIFT_W'(-cfg.bit_shift);
        shl = SHL_W'(s2_reg.sad_sc) << cfg.bit_shift[SHIFT_W-2:0];
        rnd = ((SAD_W + 1)'(s2_reg.sad_sc) + ((SAD_W + 1)'(1) << (rsh - 1'b1))) >> rsh;
        priority if (cfg.bit_shift > 0) begin
            depth_sad = (|shl[SHL_W-1:SAD_W]) ? SAD_MAX : shl[SAD_W-1:0];
        end else if (cfg.bit_shift < 0) begin
            depth_sad = rnd[SAD_W-1:0];
        end else begin
            depth_sad = s2_reg.sad_sc;
        end

        out_next.out_x        = s2_reg.out_x;
        out_next.out_y        = s2_reg.out_y;
        out_next.out_of_frame = s2_reg.oof;
        priority if (s2_reg.kind == KIND_PASS) begin
            out_next.out_sad = s2_reg.sad;
        end else if (s2_reg.oof) begin
            out_next.out_sad = cfg.fallback_sad;
        end else begin
            out_next.out_sad = depth_sad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= !fifo_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- design/motion_vector_scaler_unit.sv -----
// motion_vector_scaler_unit.sv: top level with configuration registers and checks
`default_nettype none

// Scales one block's motion vector and SAD per request. The unit takes one request
// per clock cycle at full rate while the result channel is not stalled: every
// multiply is pipelined, and the front end and the scaling pipeline are joined by
// a four-entry queue so each side can stall on its own. An accepted request passes
// through the front register, the queue and the three back-end stage registers,
// which hold up to eight requests in flight. Configuration writes take effect at
// once and are to be made only while no request is in flight.
module motion_vector_scaler_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [mvs_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [mvs_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire mvs_pkg::in_item_t               s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output mvs_pkg::out_item_t                   m_data
);
    import mvs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     push;
    q_entry_t push_data;
    logic     fifo_full;
    logic     fifo_empty;
    logic     pop;
    q_entry_t pop_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:     cfg_next.mode          = mode_t'(cfg_wdata[1:0]);
                REG_SCALE_X:  cfg_next.scale_x       = cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Y:  cfg_next.scale_y       = cfg_wdata[SCALE_W-1:0];
                REG_ADJUST:   cfg_next.adjust_subpel = cfg_wdata[0];
                REG_SHIFT:    cfg_next.bit_shift     = cfg_wdata[SHIFT_W-1:0];
                REG_PEL:      cfg_next.pel           = cfg_wdata[PEL_W-1:0];
                REG_FALLBACK: cfg_next.fallback_sad  = cfg_wdata[SAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= MODE_VEC;
            cfg_reg.scale_x       <= SCALE_RESET;
            cfg_reg.scale_y       <= SCALE_RESET;
            cfg_reg.adjust_subpel <= 1'b0;
            cfg_reg.bit_shift     <= '0;
            cfg_reg.pel           <= PEL_RESET;
            cfg_reg.fallback_sad  <= FALLBACK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mvs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    mvs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    mvs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .fifo_data  (pop_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // a replaced vector is always zero
    a_oof_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_of_frame |-> m_data.out_x == '0 && m_data.out_y == '0)
        else $error("out-of-frame result carries a nonzero vector");

    // only vectors-only mode replaces vectors
    a_oof_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_of_frame |-> cfg_reg.mode == MODE_VEC)
        else $error("out-of-frame result outside vectors-only mode");

    // front never offers a request to a full queue without holding it
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_full && $past(push) && !pop |-> !push || $stable(push_data))
        else $error("front request changed while the queue was full");

endmodule

`default_nettype wire
